// ===== design/sea_pkg.sv =====
package sea_pkg;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] KIND_GC     = 2'd0;
	localparam logic [1:0] KIND_MALLOC = 2'd1;

	localparam logic [1:0] CFG_TOTAL  = 2'd0;
	localparam logic [1:0] CFG_GC     = 2'd1;
	localparam logic [1:0] CFG_MALLOC = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_TOTAL    = 3'd2,
		ST_TYPE     = 3'd3,
		ST_NO_ENTRY = 3'd4,
		ST_BAD_FREE = 3'd5
	} sea_status_t;

	typedef struct packed {
		logic        action;
		logic [1:0]  slice_kind;
		logic [31:0] request_bytes;
		logic [7:0]  free_index;
	} sea_in_t;

	typedef struct packed {
		sea_status_t status;
		logic [7:0]  granted_index;
		logic [31:0] released_bytes;
		logic [31:0] total_in_use;
		logic [31:0] gc_in_use;
		logic [31:0] malloc_in_use;
	} sea_out_t;

	// byte counters or quotas, one per accounting class
	typedef struct packed {
		logic [31:0] total;
		logic [31:0] gc;
		logic [31:0] malloc;
	} sea_bytes_t;

	// descriptor record
	typedef struct packed {
		logic        busy;
		logic [1:0]  kind;
		logic [31:0] bytes;
	} sea_ent_t;

	typedef struct packed {
		logic     link_we;
		logic     ent_we;
		sea_ent_t ent_wdata;
	} sea_wr_t;

endpackage

// ===== design/sea_ram.sv =====
module sea_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] wd_q;
	logic             byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first: a read of the address written in the same cycle sees the new data
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q  <= mem[raddr];
			byp_q <= we && (waddr == raddr);
			wd_q  <= wdata;
		end
	end

	assign rdata = byp_q ? wd_q : rd_q;

endmodule

// ===== design/sea_calc.sv =====
module sea_calc #(
	parameter int          ENTRIES   = 256,
	parameter logic [31:0] MIN_BYTES = 32'd4096,
	parameter logic [31:0] MAX_BYTES = 32'd16777216
) (
	input  sea_pkg::sea_in_t                  req,
	input  logic [$clog2(ENTRIES+1)-1:0]      head,
	input  logic [$clog2(ENTRIES+1)-1:0]      fresh,
	input  logic [$clog2(ENTRIES+1)-1:0]      link_rd,
	input  sea_pkg::sea_bytes_t               cnt,
	input  sea_pkg::sea_bytes_t               quota,
	input  sea_pkg::sea_ent_t                 ent_rd,
	output sea_pkg::sea_out_t                 res,
	output sea_pkg::sea_bytes_t               cnt_nx,
	output logic [$clog2(ENTRIES+1)-1:0]      head_nx,
	output logic [$clog2(ENTRIES+1)-1:0]      fresh_nx,
	output sea_pkg::sea_wr_t                  wr,
	output logic [$clog2(ENTRIES)-1:0]        link_waddr,
	output logic [$clog2(ENTRIES+1)-1:0]      link_wdata,
	output logic [$clog2(ENTRIES)-1:0]        ent_waddr
);
	import sea_pkg::*;

	localparam int HW = $clog2(ENTRIES + 1);
	localparam int IW = $clog2(ENTRIES);

	function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
		sub_sat = (a >= b) ? (a - b) : 32'd0;
	endfunction

	logic [32:0]   tot_sum;
	logic [32:0]   gc_sum;
	logic [32:0]   mal_sum;
	logic          size_bad;
	logic          tot_ok;
	logic          gc_ok;
	logic          mal_ok;
	logic          empty;
	logic          from_fresh;
	logic          fidx_ok;
	logic          busy;
	logic [HW-1:0] fidx_h;
	logic [HW-1:0] pop_next;

	assign tot_sum  = {1'b0, cnt.total} + {1'b0, req.request_bytes};
	assign gc_sum   = {1'b0, cnt.gc} + {1'b0, req.request_bytes};
	assign mal_sum  = {1'b0, cnt.malloc} + {1'b0, req.request_bytes};
	assign tot_ok   = tot_sum <= {1'b0, quota.total};
	assign gc_ok    = gc_sum <= {1'b0, quota.gc};
	assign mal_ok   = mal_sum <= {1'b0, quota.malloc};
	assign size_bad = (req.request_bytes < MIN_BYTES) || (req.request_bytes > MAX_BYTES);

	assign empty      = head == HW'(ENTRIES);
	// entries at or above the fill mark were never handed out, so their link is implicit
	assign from_fresh = head == fresh;
	assign pop_next   = from_fresh ? (head + HW'(1)) : link_rd;

	assign fidx_ok = 32'(req.free_index) < 32'(ENTRIES);
	assign fidx_h  = HW'(req.free_index);
	assign busy    = fidx_ok && (fidx_h < fresh) && ent_rd.busy;

	always_comb begin
		res                = '0;
		res.status         = ST_OK;
		cnt_nx             = cnt;
		head_nx            = head;
		fresh_nx           = fresh;
		wr                 = '0;
		wr.ent_wdata       = ent_rd;
		ent_waddr          = head[IW-1:0];
		link_waddr         = IW'(req.free_index);
		link_wdata         = head;
		if (req.action == ACT_ALLOC) begin
			if (size_bad) begin
				res.status = ST_BAD_SIZE;
			end else if (!tot_ok) begin
				res.status = ST_TOTAL;
			end else if ((req.slice_kind == KIND_GC) && !gc_ok) begin
				res.status = ST_TYPE;
			end else if ((req.slice_kind == KIND_MALLOC) && !mal_ok) begin
				res.status = ST_TYPE;
			end else if (empty) begin
				res.status = ST_NO_ENTRY;
			end else begin
				head_nx = pop_next;
				if (from_fresh) begin
					fresh_nx = fresh + HW'(1);
				end
				wr.ent_we             = 1'b1;
				wr.ent_wdata.busy     = 1'b1;
				wr.ent_wdata.kind     = req.slice_kind;
				wr.ent_wdata.bytes    = req.request_bytes;
				cnt_nx.total          = tot_sum[31:0];
				if (req.slice_kind == KIND_GC) begin
					cnt_nx.gc = gc_sum[31:0];
				end else if (req.slice_kind == KIND_MALLOC) begin
					cnt_nx.malloc = mal_sum[31:0];
				end
				res.granted_index = 8'(head);
			end
		end else begin
			if (!busy) begin
				res.status = ST_BAD_FREE;
			end else begin
				// push back on the list head; record keeps kind and size, only busy drops
				wr.ent_we         = 1'b1;
				wr.ent_wdata.busy = 1'b0;
				ent_waddr         = IW'(req.free_index);
				wr.link_we        = 1'b1;
				head_nx           = fidx_h;
				cnt_nx.total      = sub_sat(cnt.total, ent_rd.bytes);
				if (ent_rd.kind == KIND_GC) begin
					cnt_nx.gc = sub_sat(cnt.gc, ent_rd.bytes);
				end else if (ent_rd.kind == KIND_MALLOC) begin
					cnt_nx.malloc = sub_sat(cnt.malloc, ent_rd.bytes);
				end
				res.released_bytes = ent_rd.bytes;
			end
		end
		res.total_in_use  = cnt_nx.total;
		res.gc_in_use     = cnt_nx.gc;
		res.malloc_in_use = cnt_nx.malloc;
	end

endmodule

// ===== design/slice_entry_allocator_with_quotas_core.sv =====
// channel  | handshake                   | word
// ---------+-----------------------------+--------------------------------------
// in       | in_valid / in_stall         | in_word  (action, kind, size, index)
// out      | out_valid / out_stall       | out_word (status, index, bytes, use)
// cfg      | cfg_we, cfg_index           | cfg_data (quota write, no handshake)
//
// One word per cycle unless out stalls; each result registers as its word retires.
// The link and record RAM reads issued at accept set the pace; the next list head
// is forwarded into the read address so back-to-back pops and pushes chain.
// Reset empties all counters; the free list starts full through a fill mark, so
// no init sweep is needed and words are taken right after reset.
// A stall on out holds the result and the staged word, which then stalls in.
module slice_entry_allocator_with_quotas_core #(
	parameter int          ENTRIES   = 256,
	parameter logic [31:0] MIN_BYTES = 32'd4096,
	parameter logic [31:0] MAX_BYTES = 32'd16777216
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  sea_pkg::sea_in_t  in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output sea_pkg::sea_out_t out_word
);
	import sea_pkg::*;

	localparam int HW = $clog2(ENTRIES + 1);
	localparam int IW = $clog2(ENTRIES);

	logic          valid_s1;
	sea_in_t       req_s1;
	logic [HW-1:0] head_q;
	logic [HW-1:0] fresh_q;
	sea_bytes_t    cnt_q;
	sea_bytes_t    quota_q;
	logic          res_valid_q;
	sea_out_t      res_q;

	logic          fire;
	logic          accept;
	logic [HW-1:0] link_rd;
	logic [$bits(sea_ent_t)-1:0] ent_rd_raw;
	sea_ent_t      ent_rd;
	sea_out_t      res;
	sea_bytes_t    cnt_nx;
	logic [HW-1:0] head_nx;
	logic [HW-1:0] fresh_nx;
	sea_wr_t       wr;
	logic [IW-1:0] link_waddr;
	logic [HW-1:0] link_wdata;
	logic [IW-1:0] ent_waddr;
	logic [HW-1:0] head_d;

	assign fire     = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;
	// head as it stands once the staged word retires
	assign head_d   = fire ? head_nx : head_q;
	assign ent_rd   = sea_ent_t'(ent_rd_raw);

	sea_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (HW)
	) u_link_ram (
		.clk   (clk),
		.we    (fire && wr.link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (head_d[IW-1:0]),
		.rdata (link_rd)
	);

	sea_ram #(
		.DEPTH (ENTRIES),
		.WIDTH ($bits(sea_ent_t))
	) u_ent_ram (
		.clk   (clk),
		.we    (fire && wr.ent_we),
		.waddr (ent_waddr),
		.wdata (wr.ent_wdata),
		.re    (accept),
		.raddr (IW'(in_word.free_index)),
		.rdata (ent_rd_raw)
	);

	sea_calc #(
		.ENTRIES   (ENTRIES),
		.MIN_BYTES (MIN_BYTES),
		.MAX_BYTES (MAX_BYTES)
	) u_calc (
		.req        (req_s1),
		.head       (head_q),
		.fresh      (fresh_q),
		.link_rd    (link_rd),
		.cnt        (cnt_q),
		.quota      (quota_q),
		.ent_rd     (ent_rd),
		.res        (res),
		.cnt_nx     (cnt_nx),
		.head_nx    (head_nx),
		.fresh_nx   (fresh_nx),
		.wr         (wr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.ent_waddr  (ent_waddr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			head_q      <= '0;
			fresh_q     <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				head_q      <= head_nx;
				fresh_q     <= fresh_nx;
				cnt_q       <= cnt_nx;
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOTAL:  quota_q.total  <= cfg_data;
				CFG_GC:     quota_q.gc     <= cfg_data;
				CFG_MALLOC: quota_q.malloc <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_word;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid = res_valid_q;
	assign out_word  = res_q;

`ifndef SYNTH
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fresh_q <= HW'(ENTRIES)) && (head_q <= HW'(ENTRIES)))
		else $error("list head or fill mark beyond table");

	a_class_sum: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q.gc} + {1'b0, cnt_q.malloc}) <= {1'b0, cnt_q.total})
		else $error("gc plus malloc bytes exceed total in use");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_q)
		else $error("retired word left no result");

	a_alloc_pops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req_s1.action == ACT_ALLOC) && (res.status == ST_OK)
		|=> head_q != $past(head_q))
		else $error("granted allocation did not advance the list head");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import sea_pkg::*;

	localparam int          ENTRIES        = 256;
	localparam logic [31:0] MIN_BYTES      = 32'd4096;
	localparam logic [31:0] MAX_BYTES      = 32'd16777216;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam logic [1:0]  KIND_STATIC    = 2'd2;
	localparam logic [1:0]  KIND_CUSTOM    = 2'd3;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_TOTAL;
	logic [31:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	sea_in_t     in_word   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	sea_out_t    out_word;

	// shadow of the descriptor table and byte accounting
	logic [8:0]  link_of  [ENTRIES];
	logic [1:0]  kind_of  [ENTRIES];
	logic [31:0] bytes_of [ENTRIES];
	bit          busy_of  [ENTRIES];
	logic [8:0]  free_head;
	sea_bytes_t  in_use;
	sea_bytes_t  quota;

	sea_out_t    alloc_outcomes[$];
	int          errors      = 0;
	int          idle_cycles = 0;
	int          hold_left   = 0;
	int          stall_pick;
	bit          fast        = 1'b0;

	slice_entry_allocator_with_quotas_core #(
		.ENTRIES  (ENTRIES),
		.MIN_BYTES(MIN_BYTES),
		.MAX_BYTES(MAX_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sum is taken one bit wider so it never wraps
	function automatic bit fits(logic [31:0] used, logic [31:0] size, logic [31:0] lim);
		return ({1'b0, used} + {1'b0, size}) <= {1'b0, lim};
	endfunction

	function automatic logic [31:0] sub_floor(logic [31:0] a, logic [31:0] b);
		return (a >= b) ? a - b : 32'd0;
	endfunction

	function automatic sea_out_t account_step(sea_in_t w);
		sea_out_t   r;
		logic [8:0] e;
		logic [7:0] f;
		r = '0;
		r.status = ST_OK;
		if (w.action == ACT_ALLOC) begin
			if (w.request_bytes < MIN_BYTES || w.request_bytes > MAX_BYTES) begin
				r.status = ST_BAD_SIZE;
			end else if (!fits(in_use.total, w.request_bytes, quota.total)) begin
				r.status = ST_TOTAL;
			end else if (w.slice_kind == KIND_GC && !fits(in_use.gc, w.request_bytes, quota.gc)) begin
				r.status = ST_TYPE;
			end else if (w.slice_kind == KIND_MALLOC &&
					!fits(in_use.malloc, w.request_bytes, quota.malloc)) begin
				r.status = ST_TYPE;
			end else if (free_head >= ENTRIES) begin
				r.status = ST_NO_ENTRY;
			end else begin
				e = free_head;
				free_head = link_of[e];
				kind_of[e] = w.slice_kind;
				bytes_of[e] = w.request_bytes;
				busy_of[e] = 1'b1;
				in_use.total = in_use.total + w.request_bytes;
				if (w.slice_kind == KIND_GC)
					in_use.gc = in_use.gc + w.request_bytes;
				else if (w.slice_kind == KIND_MALLOC)
					in_use.malloc = in_use.malloc + w.request_bytes;
				r.granted_index = e[7:0];
			end
		end else begin
			f = w.free_index;
			if (!busy_of[f]) begin
				r.status = ST_BAD_FREE;
			end else begin
				busy_of[f] = 1'b0;
				link_of[f] = free_head;
				free_head = {1'b0, f};
				in_use.total = sub_floor(in_use.total, bytes_of[f]);
				if (kind_of[f] == KIND_GC)
					in_use.gc = sub_floor(in_use.gc, bytes_of[f]);
				else if (kind_of[f] == KIND_MALLOC)
					in_use.malloc = sub_floor(in_use.malloc, bytes_of[f]);
				r.released_bytes = bytes_of[f];
			end
		end
		r.total_in_use = in_use.total;
		r.gc_in_use = in_use.gc;
		r.malloc_in_use = in_use.malloc;
		return r;
	endfunction

	// ignored fields get random content so their bits toggle too
	function automatic sea_in_t alloc_word(logic [1:0] kind, logic [31:0] size);
		sea_in_t w;
		w.action = ACT_ALLOC;
		w.slice_kind = kind;
		w.request_bytes = size;
		w.free_index = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic sea_in_t free_word(logic [7:0] idx);
		sea_in_t w;
		w.action = ACT_FREE;
		w.slice_kind = 2'($urandom_range(0, 3));
		w.request_bytes = $urandom;
		w.free_index = idx;
		return w;
	endfunction

	function automatic logic [31:0] pick_size();
		int s;
		s = $urandom_range(0, 99);
		if (s < 70)
			return $urandom_range(MIN_BYTES, 65536);
		else if (s < 90)
			return $urandom_range(MIN_BYTES, MAX_BYTES);
		else if (s < 95)
			return s[0] ? MIN_BYTES : MAX_BYTES;
		else
			return s[0] ? MIN_BYTES - 1 : MAX_BYTES + 1;
	endfunction

	// a busy descriptor if there is one, else any index
	function automatic logic [7:0] pick_busy();
		int start;
		start = $urandom_range(0, ENTRIES - 1);
		for (int i = 0; i < ENTRIES; i++)
			if (busy_of[(start + i) % ENTRIES])
				return 8'((start + i) % ENTRIES);
		return 8'(start);
	endfunction

	function automatic int pick_gap();
		int r;
		if (fast)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input sea_in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_word = w;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		alloc_outcomes.push_back(account_step(w));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (alloc_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// only called with the block idle
	task automatic write_quota(input logic [1:0] idx, input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_TOTAL:  quota.total = data;
			CFG_GC:     quota.gc = data;
			CFG_MALLOC: quota.malloc = data;
			default: ;
		endcase
	endtask

	task automatic test_size_edges();
		// quotas still at reset value: nothing fits
		send_word(alloc_word(KIND_GC, MIN_BYTES));
		drain();
		write_quota(CFG_TOTAL, ALL_ONES);
		write_quota(CFG_GC, ALL_ONES);
		write_quota(CFG_MALLOC, ALL_ONES);
		send_word(alloc_word(KIND_STATIC, 32'd0));
		send_word(alloc_word(KIND_GC, MIN_BYTES - 1));
		send_word(alloc_word(KIND_GC, MIN_BYTES));
		send_word(alloc_word(KIND_MALLOC, MAX_BYTES));
		send_word(alloc_word(KIND_CUSTOM, MAX_BYTES + 1));
		send_word(alloc_word(KIND_STATIC, ALL_ONES));
	endtask

	task automatic test_quota_rules();
		drain();
		write_quota(CFG_GC, 32'd8192);
		write_quota(CFG_MALLOC, MAX_BYTES);
		send_word(alloc_word(KIND_GC, MIN_BYTES));     // lands exactly on the gc quota
		send_word(alloc_word(KIND_GC, MIN_BYTES));
		send_word(alloc_word(KIND_MALLOC, MIN_BYTES));
		send_word(alloc_word(KIND_STATIC, MAX_BYTES)); // static and custom see only total
		send_word(alloc_word(KIND_CUSTOM, MAX_BYTES));
		drain();
		// total is checked before the kind quota
		write_quota(CFG_TOTAL, in_use.total);
		send_word(alloc_word(KIND_GC, MIN_BYTES));
		send_word(alloc_word(KIND_CUSTOM, MIN_BYTES));
		drain();
		// quota dropped under current use: counters stay, reservations fail
		write_quota(CFG_TOTAL, 32'd0);
		send_word(alloc_word(KIND_STATIC, MIN_BYTES));
		send_word(free_word(8'd0));
		send_word(alloc_word(KIND_MALLOC, MIN_BYTES));
		drain();
		write_quota(CFG_TOTAL, ALL_ONES);
		write_quota(CFG_GC, ALL_ONES);
		write_quota(CFG_MALLOC, ALL_ONES);
	endtask

	task automatic test_bad_free();
		send_word(free_word(8'd0));
		send_word(free_word(8'hFF));
		send_word(free_word(8'd1));
		send_word(free_word(8'd1));
		send_word(alloc_word(KIND_GC, MIN_BYTES));
	endtask

	task automatic test_table_full();
		int order[ENTRIES];
		int j;
		int t;
		int guard;
		guard = 0;
		while (free_head < ENTRIES && guard < 400) begin
			send_word(alloc_word(2'($urandom_range(0, 3)), $urandom_range(MIN_BYTES, 65536)));
			guard++;
			if (guard == 128)
				drain();
		end
		repeat (3)
			send_word(alloc_word(2'($urandom_range(0, 3)), pick_size()));
		for (int i = 0; i < ENTRIES; i++)
			order[i] = i;
		for (int i = ENTRIES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			send_word(free_word(8'(order[i])));
			if (i % 40 == 7)
				send_word(free_word(8'(order[i])));
		end
	endtask

	task automatic test_random_traffic();
		sea_in_t w;
		int      r;
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			case (ph)
				0: begin
					write_quota(CFG_TOTAL, $urandom_range(32'h0040_0000, 32'h0400_0000));
					write_quota(CFG_GC, $urandom_range(32'h0004_0000, 32'h0040_0000));
					write_quota(CFG_MALLOC, $urandom_range(32'h0004_0000, 32'h0040_0000));
				end
				1: begin
					fast = 1'b1;
					write_quota(CFG_TOTAL, ALL_ONES);
					write_quota(CFG_GC, 32'd0);
					write_quota(CFG_MALLOC, ALL_ONES);
				end
				default: begin
					fast = 1'b0;
					write_quota(CFG_TOTAL, $urandom_range(32'h0001_0000, 32'h0020_0000));
					write_quota(CFG_GC, $urandom_range(32'h0000_2000, 32'h0010_0000));
					write_quota(CFG_MALLOC, $urandom_range(32'h0000_2000, 32'h0010_0000));
				end
			endcase
			for (int n = 0; n < 90; n++) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					w = alloc_word(2'($urandom_range(0, 3)), pick_size());
				end else if (r < 88) begin
					w = free_word(pick_busy());
				end else begin
					w.action = 1'($urandom_range(0, 1));
					w.slice_kind = 2'($urandom_range(0, 3));
					w.request_bytes = $urandom;
					w.free_index = 8'($urandom_range(0, 255));
				end
				send_word(w);
			end
		end
		fast = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			link_of[i] = 9'(i + 1);
			kind_of[i] = '0;
			bytes_of[i] = '0;
			busy_of[i] = 1'b0;
		end
		free_head = '0;
		in_use = '0;
		quota = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_size_edges();
		test_quota_rules();
		test_bad_free();
		test_table_full();
		test_random_traffic();

		in_valid = 1'b0;
		while (alloc_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver backpressure: mostly short runs, a few long stalls
	always @(negedge clk) begin
		if (!arst_n || fast) begin
			out_stall = 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 60) begin
				out_stall = 1'b0;
				hold_left = $urandom_range(0, 6);
			end else if (stall_pick < 93) begin
				out_stall = 1'b1;
				hold_left = $urandom_range(0, 3);
			end else begin
				out_stall = 1'b1;
				hold_left = $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin : result_check
		sea_out_t want;
		sea_out_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = out_word;
			if (alloc_outcomes.size() == 0) begin
				$error("result word with nothing pending: status %0d", got.status);
				errors++;
			end else begin
				want = alloc_outcomes.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.granted_index !== want.granted_index) begin
					$error("granted_index: expected %0d, got %0d",
						want.granted_index, got.granted_index);
					errors++;
				end
				if (got.released_bytes !== want.released_bytes) begin
					$error("released_bytes: expected %0d, got %0d",
						want.released_bytes, got.released_bytes);
					errors++;
				end
				if (got.total_in_use !== want.total_in_use) begin
					$error("total_in_use: expected %0d, got %0d",
						want.total_in_use, got.total_in_use);
					errors++;
				end
				if (got.gc_in_use !== want.gc_in_use) begin
					$error("gc_in_use: expected %0d, got %0d", want.gc_in_use, got.gc_in_use);
					errors++;
				end
				if (got.malloc_in_use !== want.malloc_in_use) begin
					$error("malloc_in_use: expected %0d, got %0d",
						want.malloc_in_use, got.malloc_in_use);
					errors++;
				end
			end
		end
	end

	// no word moving on either side for too long means the block hung
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
design/sea_pkg.sv
design/sea_ram.sv
design/sea_calc.sv
design/slice_entry_allocator_with_quotas_core.sv
test/tb_top.sv
